FILE: sv/tsti_pkg.sv
// ----------------------------------------------------------------------------
// Timed sample table interpolator package
// Widths, status codes, state types, interpolation unit interface and the
// Kelvin conversion shared by the sequencer, the interpolation unit and the
// port checker.
// ----------------------------------------------------------------------------
package tsti_pkg;

    // Table geometry.
    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int RD_W        = $clog2(TABLE_DEPTH + 2);

    // Field widths.
    localparam int TIME_W    = 40;
    localparam int TEMP_W    = 16;
    localparam int KEL_W     = 17;
    localparam int STATUS_W  = 3;
    localparam int MW_W      = 16;
    localparam int SG_W      = 20;
    localparam int LM_W      = 16;
    localparam int CFG_W     = 20;
    localparam int CFG_IDX_W = 2;

    // Scan and interpolation arithmetic widths.
    localparam int SCAN_W  = TIME_W + 2;
    localparam int OFF_W   = TIME_W + 1;
    localparam int MAG_W   = TEMP_W;
    localparam int DELTA_W = TEMP_W + 1;
    localparam int QUO_W   = TEMP_W + 1;
    localparam int PROD_W  = OFF_W + MAG_W;
    localparam int ACC_W   = PROD_W + 1;
    localparam int STEP_W  = $clog2(QUO_W + 1);
    localparam int SUM_W   = TEMP_W + 3;

    // Kelvin conversion in Q8.
    localparam int KELVIN_OFFSET_Q8 = 69926;
    localparam int KEL_MAX          = (1 << KEL_W) - 1;

    // Configuration reset values.
    localparam logic [MW_W-1:0] MW_RESET = MW_W'(16);
    localparam logic [SG_W-1:0] SG_RESET = SG_W'(1600);
    localparam logic [LM_W-1:0] LM_RESET = LM_W'(160);

    // Item modes.
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_STORED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EXACT     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_INTERP    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MATCH_WINDOW = 2'd0,
        CFG_STOP_GAP     = 2'd1,
        CFG_LEAD_MARGIN  = 2'd2
    } cfg_idx_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_LERP,
        S_FINISH
    } seq_state_t;

    // Interpolation unit states.
    typedef enum logic [1:0] {
        L_IDLE,
        L_MUL,
        L_RND,
        L_DIV
    } lerp_state_t;

    // Request to the interpolation unit.
    typedef struct packed {
        logic             start;
        logic [OFF_W-1:0] off;
        logic [OFF_W-1:0] span;
        logic [MAG_W-1:0] mag;
    } lerp_req_t;

    // Answer from the interpolation unit.
    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quo;
    } lerp_resp_t;

    // Celsius Q8 to Kelvin Q8, saturated to the output range.
    function automatic logic [KEL_W-1:0] to_kelvin(input logic signed [SUM_W-1:0] c_q8);
        logic signed [SUM_W:0] k;
        k = $signed({c_q8[SUM_W-1], c_q8}) + $signed((SUM_W + 1)'(KELVIN_OFFSET_Q8));
        if (k[SUM_W])
        begin
            return '0;
        end
        else if (k > $signed((SUM_W + 1)'(KEL_MAX)))
        begin
            return KEL_W'(KEL_MAX);
        end
        else
        begin
            return k[KEL_W-1:0];
        end
    endfunction

endpackage

FILE: sv/tsti_lerp_unit.sv
// ----------------------------------------------------------------------------
// Interpolation unit
// Computes round(off * mag / span) with one shared adder: a shift-add
// multiply, a rounding add of half the span, then a restoring division that
// yields one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tsti_lerp_unit
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  tsti_pkg::lerp_req_t    req,
    output tsti_pkg::lerp_resp_t   resp
);

    tsti_pkg::lerp_state_t state_reg, state_next;

    logic [tsti_pkg::ACC_W-1:0]  acc_reg, acc_next;
    logic [tsti_pkg::PROD_W-1:0] opb_reg, opb_next;
    logic [tsti_pkg::OFF_W-1:0]  span_reg, span_next;
    logic [tsti_pkg::MAG_W-1:0]  mag_reg, mag_next;
    logic [tsti_pkg::STEP_W-1:0] step_reg, step_next;
    logic [tsti_pkg::QUO_W-1:0]  quo_reg, quo_next;
    logic                        done_reg, done_next;

    logic [tsti_pkg::ACC_W-1:0]  opb_sel;
    logic                        sub_sel;
    logic [tsti_pkg::ACC_W:0]    sum_full;
    logic                        carry;

    // Operand selection for the shared adder.
    always_comb
    begin
        opb_sel = '0;
        sub_sel = 1'b0;
        case (state_reg)
            tsti_pkg::L_MUL:
            begin
                opb_sel = mag_reg[0] ? tsti_pkg::ACC_W'(opb_reg) : '0;
            end
            tsti_pkg::L_RND:
            begin
                opb_sel = tsti_pkg::ACC_W'(span_reg >> 1);
            end
            tsti_pkg::L_DIV:
            begin
                opb_sel = tsti_pkg::ACC_W'(opb_reg);
                sub_sel = 1'b1;
            end
            default:
            begin
                opb_sel = '0;
            end
        endcase
    end

    // Shared adder; on subtract the carry says the accumulator was not below.
    assign sum_full = {1'b0, acc_reg} + {1'b0, (sub_sel ? ~opb_sel : opb_sel)}
                    + (tsti_pkg::ACC_W + 1)'(sub_sel);
    assign carry    = sum_full[tsti_pkg::ACC_W];

    // Sequencer for multiply, round and divide.
    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        opb_next   = opb_reg;
        span_next  = span_reg;
        mag_next   = mag_reg;
        step_next  = step_reg;
        quo_next   = quo_reg;
        done_next  = 1'b0;
        case (state_reg)
            tsti_pkg::L_IDLE:
            begin
                if (req.start)
                begin
                    acc_next   = '0;
                    opb_next   = tsti_pkg::PROD_W'(req.off);
                    span_next  = req.span;
                    mag_next   = req.mag;
                    step_next  = '0;
                    state_next = tsti_pkg::L_MUL;
                end
            end
            tsti_pkg::L_MUL:
            begin
                acc_next  = sum_full[tsti_pkg::ACC_W-1:0];
                opb_next  = opb_reg << 1;
                mag_next  = mag_reg >> 1;
                step_next = step_reg + 1'b1;
                if (step_reg == tsti_pkg::STEP_W'(tsti_pkg::MAG_W - 1))
                begin
                    state_next = tsti_pkg::L_RND;
                end
            end
            tsti_pkg::L_RND:
            begin
                acc_next = sum_full[tsti_pkg::ACC_W-1:0];
                quo_next = '0;
                if (span_reg == '0)
                begin
                    done_next  = 1'b1;
                    state_next = tsti_pkg::L_IDLE;
                end
                else
                begin
                    opb_next   = {span_reg, {(tsti_pkg::QUO_W - 1){1'b0}}};
                    step_next  = tsti_pkg::STEP_W'(tsti_pkg::QUO_W - 1);
                    state_next = tsti_pkg::L_DIV;
                end
            end
            tsti_pkg::L_DIV:
            begin
                if (carry)
                begin
                    acc_next = sum_full[tsti_pkg::ACC_W-1:0];
                end
                quo_next  = {quo_reg[tsti_pkg::QUO_W-2:0], carry};
                opb_next  = opb_reg >> 1;
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    done_next  = 1'b1;
                    state_next = tsti_pkg::L_IDLE;
                end
            end
            default:
            begin
                state_next = tsti_pkg::L_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tsti_pkg::L_IDLE;
            done_reg  <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            step_reg  <= step_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        opb_reg  <= opb_next;
        span_reg <= span_next;
        mag_reg  <= mag_next;
        quo_reg  <= quo_next;
    end

    assign resp.done = done_reg;
    assign resp.quo  = quo_reg;

endmodule

FILE: sv/timed_sample_table_interpolator.sv
// ----------------------------------------------------------------------------
// Timed sample table interpolator
// Holds up to 1024 timestamped temperature samples. Load words append a
// sample; query words scan the table in order and return an exact match or a
// linear interpolation between neighboring samples, in Kelvin Q8.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Payload
//  -------   ------------------   -----------------------------------------------
//  config    cfg_wr_en            cfg_index, cfg_data
//  input     in_valid / in_ready  mode, clear_table, time_stamp, temp_celsius
//  output    out_valid/out_ready  status, temp_kelvin, entry_count, is_sorted
//
//  A load word passes through the finish state into the output register once it is free.
//  A query reads one table entry per cycle from the sample memory and, when it
//  interpolates, then waits for the shift-add multiply, rounding add and restoring
//  divide of the interpolation unit. in_ready is high only while the sequencer is
//  idle; a new word is taken while a result still waits in the output register.
//  Reset is asynchronous and needs no clearing pass: entries above the fill count
//  are never read.
// ----------------------------------------------------------------------------
module timed_sample_table_interpolator
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [tsti_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tsti_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 mode,
    input  logic                                 clear_table,
    input  logic [tsti_pkg::TIME_W-1:0]          time_stamp,
    input  logic signed [tsti_pkg::TEMP_W-1:0]   temp_celsius,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [tsti_pkg::STATUS_W-1:0]        status,
    output logic [tsti_pkg::KEL_W-1:0]           temp_kelvin,
    output logic [tsti_pkg::CNT_W-1:0]           entry_count,
    output logic                                 is_sorted
);

    // Sample memories.
    logic [tsti_pkg::TIME_W-1:0]        time_mem [tsti_pkg::TABLE_DEPTH];
    logic signed [tsti_pkg::TEMP_W-1:0] temp_mem [tsti_pkg::TABLE_DEPTH];
    logic [tsti_pkg::TIME_W-1:0]        ct_rd_reg;
    logic signed [tsti_pkg::TEMP_W-1:0] cc_rd_reg;

    // Configuration registers.
    logic [tsti_pkg::MW_W-1:0] match_window_reg, match_window_next;
    logic [tsti_pkg::SG_W-1:0] stop_gap_reg, stop_gap_next;
    logic [tsti_pkg::LM_W-1:0] lead_margin_reg, lead_margin_next;

    // Table state.
    logic [tsti_pkg::CNT_W-1:0]  fill_count_reg, fill_count_next;
    logic                        table_sorted_reg, table_sorted_next;
    logic [tsti_pkg::TIME_W-1:0] last_time_reg, last_time_next;

    // Sequencer and scan state.
    tsti_pkg::seq_state_t               state_reg, state_next;
    logic [tsti_pkg::RD_W-1:0]          rd_idx_reg, rd_idx_next;
    logic                               data_vld_reg, data_vld_next;
    logic                               first_reg, first_next;
    logic [tsti_pkg::TIME_W-1:0]        q_reg, q_next;
    logic signed [tsti_pkg::SCAN_W-1:0] pt_reg, pt_next;
    logic signed [tsti_pkg::TEMP_W-1:0] pc_reg, pc_next;
    logic                               neg_reg, neg_next;
    logic [tsti_pkg::STATUS_W-1:0]      res_status_reg, res_status_next;
    logic [tsti_pkg::KEL_W-1:0]         res_kel_reg, res_kel_next;

    // Output register.
    logic                          out_valid_reg, out_valid_next;
    logic [tsti_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [tsti_pkg::KEL_W-1:0]    temp_kelvin_reg, temp_kelvin_next;
    logic [tsti_pkg::CNT_W-1:0]    entry_count_reg, entry_count_next;
    logic                          is_sorted_reg, is_sorted_next;

    // Load path.
    logic                        accept;
    logic [tsti_pkg::CNT_W-1:0]  eff_count;
    logic                        eff_sorted;
    logic                        table_full;
    logic                        mem_we;

    // Scan compare path.
    logic signed [tsti_pkg::SCAN_W-1:0]  q_s, ct_s, pt_eff, diff_s, abs_s;
    logic signed [tsti_pkg::SCAN_W-1:0]  win_s, gap_s, lead_s;
    logic signed [tsti_pkg::TEMP_W-1:0]  pc_eff;
    logic signed [tsti_pkg::DELTA_W-1:0] delta_s;
    logic                                is_exact, is_between, is_stop;
    logic signed [tsti_pkg::SUM_W-1:0]   interp_sum;

    tsti_pkg::lerp_req_t  lerp_req;
    tsti_pkg::lerp_resp_t lerp_resp;

    assign in_ready = (state_reg == tsti_pkg::S_IDLE);
    assign accept   = in_valid && in_ready;

    // A clearing load starts from an empty, sorted table.
    assign eff_count  = clear_table ? '0 : fill_count_reg;
    assign eff_sorted = clear_table ? 1'b1 : table_sorted_reg;
    assign table_full = (eff_count == tsti_pkg::CNT_W'(tsti_pkg::TABLE_DEPTH));
    assign mem_we     = accept && (mode == tsti_pkg::MODE_LOAD) && !table_full;

    // Sample memory write on load and registered read during the scan.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            time_mem[eff_count[tsti_pkg::ADDR_W-1:0]] <= time_stamp;
            temp_mem[eff_count[tsti_pkg::ADDR_W-1:0]] <= temp_celsius;
        end
        ct_rd_reg <= time_mem[rd_idx_reg[tsti_pkg::ADDR_W-1:0]];
        cc_rd_reg <= temp_mem[rd_idx_reg[tsti_pkg::ADDR_W-1:0]];
    end

    // Compare the entry just read against the query time.
    always_comb
    begin
        q_s    = $signed(tsti_pkg::SCAN_W'(q_reg));
        ct_s   = $signed(tsti_pkg::SCAN_W'(ct_rd_reg));
        win_s  = $signed(tsti_pkg::SCAN_W'(match_window_reg));
        gap_s  = $signed(tsti_pkg::SCAN_W'(stop_gap_reg));
        lead_s = $signed(tsti_pkg::SCAN_W'(lead_margin_reg));
        // The first entry's predecessor sits a lead margin earlier.
        pt_eff = first_reg ? (ct_s - lead_s) : pt_reg;
        pc_eff = first_reg ? cc_rd_reg : pc_reg;
        diff_s = ct_s - q_s;
        abs_s  = diff_s[tsti_pkg::SCAN_W-1] ? -diff_s : diff_s;
        is_exact   = (abs_s <= win_s);
        is_between = (pt_eff <= q_s) && (q_s <= ct_s);
        is_stop    = table_sorted_reg && (diff_s > gap_s);
        delta_s    = $signed({cc_rd_reg[tsti_pkg::TEMP_W-1], cc_rd_reg})
                   - $signed({pc_eff[tsti_pkg::TEMP_W-1], pc_eff});
    end

    // Interpolation request, raised for one cycle on a bracketing entry.
    assign lerp_req.start = (state_reg == tsti_pkg::S_SCAN) && data_vld_reg
                          && !is_exact && is_between;
    assign lerp_req.off   = tsti_pkg::OFF_W'(q_s - pt_eff);
    assign lerp_req.span  = tsti_pkg::OFF_W'(ct_s - pt_eff);
    assign lerp_req.mag   = tsti_pkg::MAG_W'(delta_s[tsti_pkg::DELTA_W-1] ? -delta_s
                                                                        : delta_s);

    tsti_lerp_unit u_lerp
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (lerp_req),
        .resp  (lerp_resp)
    );

    // Predecessor temperature plus or minus the rounded quotient.
    assign interp_sum = neg_reg
        ? ($signed(tsti_pkg::SUM_W'(pc_reg)) - $signed(tsti_pkg::SUM_W'(lerp_resp.quo)))
        : ($signed(tsti_pkg::SUM_W'(pc_reg)) + $signed(tsti_pkg::SUM_W'(lerp_resp.quo)));

    // Configuration writes.
    always_comb
    begin
        match_window_next = match_window_reg;
        stop_gap_next     = stop_gap_reg;
        lead_margin_next  = lead_margin_reg;
        if (cfg_wr_en)
        begin
            case (tsti_pkg::cfg_idx_t'(cfg_index))
                tsti_pkg::CFG_MATCH_WINDOW:
                begin
                    match_window_next = cfg_data[tsti_pkg::MW_W-1:0];
                end
                tsti_pkg::CFG_STOP_GAP:
                begin
                    stop_gap_next = cfg_data[tsti_pkg::SG_W-1:0];
                end
                tsti_pkg::CFG_LEAD_MARGIN:
                begin
                    lead_margin_next = cfg_data[tsti_pkg::LM_W-1:0];
                end
                default:
                begin
                    match_window_next = match_window_reg;
                end
            endcase
        end
    end

    // Sequencer: load, scan, interpolate, hand over to the output register.
    always_comb
    begin
        state_next        = state_reg;
        fill_count_next   = fill_count_reg;
        table_sorted_next = table_sorted_reg;
        last_time_next    = last_time_reg;
        rd_idx_next       = rd_idx_reg;
        data_vld_next     = data_vld_reg;
        first_next        = first_reg;
        q_next            = q_reg;
        pt_next           = pt_reg;
        pc_next           = pc_reg;
        neg_next          = neg_reg;
        res_status_next   = res_status_reg;
        res_kel_next      = res_kel_reg;
        out_valid_next    = out_valid_reg;
        status_next       = status_reg;
        temp_kelvin_next  = temp_kelvin_reg;
        entry_count_next  = entry_count_reg;
        is_sorted_next    = is_sorted_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            tsti_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    res_kel_next = '0;
                    state_next   = tsti_pkg::S_FINISH;
                    if (mode == tsti_pkg::MODE_LOAD)
                    begin
                        if (table_full)
                        begin
                            res_status_next = tsti_pkg::ST_FULL;
                        end
                        else
                        begin
                            res_status_next   = tsti_pkg::ST_STORED;
                            fill_count_next   = eff_count + 1'b1;
                            table_sorted_next = eff_sorted
                                && !((eff_count != '0) && (time_stamp < last_time_reg));
                            last_time_next    = time_stamp;
                        end
                    end
                    else
                    begin
                        res_status_next = tsti_pkg::ST_NOT_FOUND;
                        q_next          = time_stamp;
                        if (fill_count_reg != '0)
                        begin
                            rd_idx_next   = '0;
                            data_vld_next = 1'b0;
                            first_next    = 1'b1;
                            state_next    = tsti_pkg::S_SCAN;
                        end
                    end
                end
            end
            tsti_pkg::S_SCAN:
            begin
                rd_idx_next   = rd_idx_reg + 1'b1;
                data_vld_next = (rd_idx_reg < tsti_pkg::RD_W'(fill_count_reg));
                if (data_vld_reg)
                begin
                    first_next = 1'b0;
                    pt_next    = ct_s;
                    pc_next    = cc_rd_reg;
                    if (is_exact)
                    begin
                        res_status_next = tsti_pkg::ST_EXACT;
                        res_kel_next    = tsti_pkg::to_kelvin(
                                              tsti_pkg::SUM_W'(cc_rd_reg));
                        state_next      = tsti_pkg::S_FINISH;
                    end
                    else if (is_between)
                    begin
                        pc_next    = pc_eff;
                        neg_next   = delta_s[tsti_pkg::DELTA_W-1];
                        state_next = tsti_pkg::S_LERP;
                    end
                    else if (is_stop)
                    begin
                        state_next = tsti_pkg::S_FINISH;
                    end
                end
                else if (rd_idx_reg != '0)
                begin
                    // Every stored entry has been checked without a hit.
                    state_next = tsti_pkg::S_FINISH;
                end
            end
            tsti_pkg::S_LERP:
            begin
                if (lerp_resp.done)
                begin
                    res_status_next = tsti_pkg::ST_INTERP;
                    res_kel_next    = tsti_pkg::to_kelvin(interp_sum);
                    state_next      = tsti_pkg::S_FINISH;
                end
            end
            tsti_pkg::S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    status_next      = res_status_reg;
                    temp_kelvin_next = res_kel_reg;
                    entry_count_next = fill_count_reg;
                    is_sorted_next   = table_sorted_reg;
                    state_next       = tsti_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = tsti_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= tsti_pkg::S_IDLE;
            match_window_reg <= tsti_pkg::MW_RESET;
            stop_gap_reg     <= tsti_pkg::SG_RESET;
            lead_margin_reg  <= tsti_pkg::LM_RESET;
            fill_count_reg   <= '0;
            table_sorted_reg <= 1'b1;
            last_time_reg    <= '0;
            rd_idx_reg       <= '0;
            data_vld_reg     <= 1'b0;
            first_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            match_window_reg <= match_window_next;
            stop_gap_reg     <= stop_gap_next;
            lead_margin_reg  <= lead_margin_next;
            fill_count_reg   <= fill_count_next;
            table_sorted_reg <= table_sorted_next;
            last_time_reg    <= last_time_next;
            rd_idx_reg       <= rd_idx_next;
            data_vld_reg     <= data_vld_next;
            first_reg        <= first_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        q_reg           <= q_next;
        pt_reg          <= pt_next;
        pc_reg          <= pc_next;
        neg_reg         <= neg_next;
        res_status_reg  <= res_status_next;
        res_kel_reg     <= res_kel_next;
        status_reg      <= status_next;
        temp_kelvin_reg <= temp_kelvin_next;
        entry_count_reg <= entry_count_next;
        is_sorted_reg   <= is_sorted_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign temp_kelvin = temp_kelvin_reg;
    assign entry_count = entry_count_reg;
    assign is_sorted   = is_sorted_reg;

endmodule

FILE: sv/tsti_checker.sv
// ----------------------------------------------------------------------------
// Timed sample table interpolator port checker
// Watches the top level's ports for handshake and result consistency and is
// attached to every instance of the top level.
// ----------------------------------------------------------------------------
module tsti_checker
(
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic [tsti_pkg::STATUS_W-1:0]       status,
    input logic [tsti_pkg::KEL_W-1:0]          temp_kelvin,
    input logic [tsti_pkg::CNT_W-1:0]          entry_count,
    input logic                                is_sorted
);

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
                                    && $stable(temp_kelvin) && $stable(entry_count)
                                    && $stable(is_sorted))
        else $error("result word changed while stalled");

    // The sequencer drops in_ready right after taking a word.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again right after acceptance");

    // Only a match or an interpolation carries a temperature.
    a_kelvin_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != tsti_pkg::ST_EXACT) && (status != tsti_pkg::ST_INTERP)
        |-> temp_kelvin == '0)
        else $error("temperature set on a result without one");

    // A full report comes only from a full table.
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == tsti_pkg::ST_FULL)
        |-> entry_count == tsti_pkg::CNT_W'(tsti_pkg::TABLE_DEPTH))
        else $error("table full reported below capacity");

endmodule

bind timed_sample_table_interpolator tsti_checker u_tsti_checker (.*);
